### src/lgfpd_pkg.sv
// Package for the LED grid frame packet driver.
// Holds default sizes, command codes, state and refresh types, and a small helper.
// No dependencies.
`default_nettype none

package lgfpd_pkg;

  // Default grid size
  localparam int NUM_COLUMNS_DEF = 12;
  localparam int NUM_ROWS_DEF    = 12;

  // Field widths of one transfer
  localparam int OPCODE_W = 3;
  localparam int COLUMN_W = 4;
  localparam int ROW_W    = 4;
  localparam int LEVEL_W  = 8;
  localparam int STRIPE_W = 4;
  localparam int SLOT_W   = 2;
  localparam int PACKET_W = 32;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Driver write command byte, first byte on the wire
  localparam logic [7:0] WRITE_CMD = 8'h3A;

  // Byte positions inside one stored driver word (lowest row in the top byte)
  localparam logic [1:0] BYTE_ROW0 = 2'd0;
  localparam logic [1:0] BYTE_ROW1 = 2'd1;
  localparam logic [1:0] BYTE_ROW2 = 2'd2;

  typedef enum logic [2:0] {
    OP_WRITE_PX = 3'd0,
    OP_SET_PX   = 3'd1,
    OP_FILL_COL = 3'd2,
    OP_FILL_ROW = 3'd3,
    OP_FILL_ALL = 3'd4,
    OP_REF_COL  = 3'd5,
    OP_REF_ALL  = 3'd6,
    OP_NONE     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_ROW,
    ST_WB,
    ST_REFRESH
  } state_t;

  typedef enum logic [1:0] {
    REF_NONE,
    REF_COL,
    REF_ALL
  } refresh_t;

  // Split a row index into driver index (row / 3) and byte position (row % 3).
  // row * 11 >> 5 gives row / 3 exactly for every 4-bit row.
  function automatic logic [4:0] row_split(input logic [3:0] row);
    logic [7:0] prod;
    logic [2:0] quo;
    logic [3:0] rem;
    prod = 8'(row) * 8'd11;
    quo  = prod[7:5];
    rem  = row - (4'(quo) * 4'd3);
    return {quo, rem[1:0]};
  endfunction

endpackage

`default_nettype wire

### src/lgfpd_store.sv
// Frame store: one 24-bit word per driver, one write port and one read port.
// Read data is registered and holds when no read is issued.
// Depends on nothing outside this file.
`default_nettype none

module lgfpd_store #(
  parameter int DEPTH = 48,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [23:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [23:0]   rd_data
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### src/led_grid_frame_packet_driver.sv
// LED grid frame packet driver, top level.
// Uses lgfpd_pkg for codes and types and lgfpd_store for the frame memory.
// Command in on the in_ stream, driver packets out on the out_ stream.
`default_nettype none

// The block keeps a NUM_COLUMNS by NUM_ROWS brightness grid in one memory, stored
// as one 24-bit word per driver (three rows). Each command takes one in_ transfer;
// the next one is taken once the previous command has issued all its memory work,
// while its last packets may still wait in the output stages. After reset a
// clearing pass writes zero to every word, NUM_COLUMNS * ceil(NUM_ROWS/3) words
// (48 with the defaults), with in_tready low. Bound by the single memory read port
// and the single write port, a refresh sends one packet per cycle (4 for one
// column, 48 for all with the defaults) when out_tready stays high; a pixel write
// first reads its word, merges in the new byte and writes it back; a row fill does
// so for each column; a column fill writes each word of its column and a fill of
// the whole grid writes every word before its refresh. Each packet carries the
// command byte 0x3A in bits 31..24 and the three rows of its driver below, lowest
// row first; rows beyond the grid read as zero. out_tlast marks the final packet
// of a command. Commands with an out-of-range column or row, and the unused
// opcode, are taken and dropped.

module led_grid_frame_packet_driver #(
  parameter int NUM_COLUMNS = lgfpd_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_ROWS    = lgfpd_pkg::NUM_ROWS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // opcode [2:0], column [6:3], row [10:7], level [18:11], zero pad [23:19]
  input  wire logic [lgfpd_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // stripe [3:0], driver_slot [5:4], packet [37:6], zero pad [39:38]
  output logic      [lgfpd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                    out_tlast
);

  localparam int DRV       = (NUM_ROWS + 2) / 3;
  localparam int DEPTH     = NUM_COLUMNS * DRV;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W     = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int DRV_W     = (DRV > 1) ? $clog2(DRV) : 1;
  localparam int LAST_ROWS = NUM_ROWS - 3 * (DRV - 1);

  // Input fields
  logic [lgfpd_pkg::OPCODE_W-1:0] in_opcode;
  logic [lgfpd_pkg::COLUMN_W-1:0] in_column;
  logic [lgfpd_pkg::ROW_W-1:0]    in_row;
  logic [lgfpd_pkg::LEVEL_W-1:0]  in_level;

  assign in_opcode = in_tdata[2:0];
  assign in_column = in_tdata[6:3];
  assign in_row    = in_tdata[10:7];
  assign in_level  = in_tdata[18:11];

  // Control state
  lgfpd_pkg::state_t   state_r, state_nxt;
  lgfpd_pkg::refresh_t ref_r, ref_nxt;
  logic                all_r, all_nxt;
  logic [COL_W-1:0]    col_cnt_r, col_cnt_nxt;
  logic [DRV_W-1:0]    drv_cnt_r, drv_cnt_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic                rmw_wr_r, rmw_wr_nxt;
  logic                rd_valid_r, rd_valid_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers
  logic [COL_W-1:0]    tgt_col_r, tgt_col_nxt;
  logic [AW-1:0]       tgt_base_r, tgt_base_nxt;
  logic [7:0]          lvl_r, lvl_nxt;
  logic [1:0]          bsel_r, bsel_nxt;
  logic [AW-1:0]       rmw_addr_r, rmw_addr_nxt;
  logic [lgfpd_pkg::STRIPE_W-1:0] rd_stripe_r, rd_stripe_nxt;
  logic [lgfpd_pkg::SLOT_W-1:0]   rd_slot_r, rd_slot_nxt;
  logic                rd_last_r, rd_last_nxt;
  logic [lgfpd_pkg::STRIPE_W-1:0] out_stripe_r;
  logic [lgfpd_pkg::SLOT_W-1:0]   out_slot_r;
  logic [23:0]         out_data_r;
  logic                out_last_r;

  // Memory port
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [23:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [23:0]   mem_rd_data;

  // Decode helpers
  logic          in_fire;
  logic          col_ok;
  logic          row_ok;
  logic [4:0]    row_parts;
  logic [AW-1:0] col_base;
  logic [AW-1:0] row_off;
  logic          last_drv;
  logic          last_col;
  logic          sweep_end;
  logic          out_load;
  logic          rd_room;
  logic [23:0]   fill_word;
  logic [23:0]   merged_word;

  assign in_tready = (state_r == lgfpd_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign col_ok    = int'(in_column) < NUM_COLUMNS;
  assign row_ok    = int'(in_row) < NUM_ROWS;
  assign row_parts = lgfpd_pkg::row_split(in_row);
  assign col_base  = AW'(int'(in_column) * DRV);
  assign row_off   = AW'(row_parts[4:2]);

  assign last_drv  = (drv_cnt_r == DRV_W'(DRV - 1));
  assign last_col  = !all_r || (col_cnt_r == COL_W'(NUM_COLUMNS - 1));
  assign sweep_end = last_drv && last_col;

  // Output register loads from the read stage; the read stage refills behind it
  assign out_load = rd_valid_r && (!out_valid_r || out_tready);
  assign rd_room  = !rd_valid_r || out_load;

  // Fill word: bytes for rows past the grid stay zero on the last driver
  always_comb begin
    fill_word = {lvl_r, lvl_r, lvl_r};
    if (last_drv) begin
      fill_word[15:8] = (LAST_ROWS > 1) ? lvl_r : 8'h00;
      fill_word[7:0]  = (LAST_ROWS > 2) ? lvl_r : 8'h00;
    end
  end

  // Replace one byte of the word just read
  always_comb begin
    merged_word = mem_rd_data;
    unique case (bsel_r)
      lgfpd_pkg::BYTE_ROW0: merged_word[23:16] = lvl_r;
      lgfpd_pkg::BYTE_ROW1: merged_word[15:8]  = lvl_r;
      lgfpd_pkg::BYTE_ROW2: merged_word[7:0]   = lvl_r;
      default:              merged_word        = mem_rd_data;
    endcase
  end

  // Write port: sweeps in CLEAR/FILL, read-modify-write back otherwise
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = addr_r;
    mem_wr_data = merged_word;
    if (state_r == lgfpd_pkg::ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_data = '0;
    end else if (state_r == lgfpd_pkg::ST_FILL) begin
      mem_wr_en   = 1'b1;
      mem_wr_data = fill_word;
    end else if (rmw_wr_r) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = rmw_addr_r;
    end
  end

  // Sequencer: next state, counters and read issue
  always_comb begin
    state_nxt     = state_r;
    ref_nxt       = ref_r;
    all_nxt       = all_r;
    col_cnt_nxt   = col_cnt_r;
    drv_cnt_nxt   = drv_cnt_r;
    addr_nxt      = addr_r;
    tgt_col_nxt   = tgt_col_r;
    tgt_base_nxt  = tgt_base_r;
    lvl_nxt       = lvl_r;
    bsel_nxt      = bsel_r;
    rmw_wr_nxt    = 1'b0;
    rmw_addr_nxt  = rmw_addr_r;
    mem_rd_en     = 1'b0;
    rd_valid_nxt  = rd_valid_r && !out_load;
    rd_stripe_nxt = rd_stripe_r;
    rd_slot_nxt   = rd_slot_r;
    rd_last_nxt   = rd_last_r;

    unique case (state_r)
      lgfpd_pkg::ST_CLEAR: begin
        // advance the clearing sweep over every word
        addr_nxt = addr_r + AW'(1);
        if (last_drv) begin
          drv_cnt_nxt = '0;
          col_cnt_nxt = col_cnt_r + COL_W'(1);
        end else begin
          drv_cnt_nxt = drv_cnt_r + DRV_W'(1);
        end
        if (sweep_end) begin
          state_nxt = lgfpd_pkg::ST_IDLE;
        end
      end

      lgfpd_pkg::ST_IDLE: begin
        if (in_fire) begin
          lvl_nxt      = in_level;
          bsel_nxt     = row_parts[1:0];
          tgt_col_nxt  = COL_W'(in_column);
          tgt_base_nxt = col_base;
          drv_cnt_nxt  = '0;
          unique case (lgfpd_pkg::op_t'(in_opcode))
            lgfpd_pkg::OP_WRITE_PX, lgfpd_pkg::OP_SET_PX: begin
              if (col_ok && row_ok) begin
                state_nxt   = lgfpd_pkg::ST_ROW;
                all_nxt     = 1'b0;
                col_cnt_nxt = COL_W'(in_column);
                addr_nxt    = col_base + row_off;
                ref_nxt     = (lgfpd_pkg::op_t'(in_opcode) == lgfpd_pkg::OP_SET_PX) ?
                              lgfpd_pkg::REF_COL : lgfpd_pkg::REF_NONE;
              end
            end
            lgfpd_pkg::OP_FILL_COL: begin
              if (col_ok) begin
                state_nxt   = lgfpd_pkg::ST_FILL;
                all_nxt     = 1'b0;
                col_cnt_nxt = COL_W'(in_column);
                addr_nxt    = col_base;
                ref_nxt     = lgfpd_pkg::REF_COL;
              end
            end
            lgfpd_pkg::OP_FILL_ROW: begin
              if (row_ok) begin
                state_nxt   = lgfpd_pkg::ST_ROW;
                all_nxt     = 1'b1;
                col_cnt_nxt = '0;
                addr_nxt    = row_off;
                ref_nxt     = lgfpd_pkg::REF_ALL;
              end
            end
            lgfpd_pkg::OP_FILL_ALL: begin
              state_nxt   = lgfpd_pkg::ST_FILL;
              all_nxt     = 1'b1;
              col_cnt_nxt = '0;
              addr_nxt    = '0;
              ref_nxt     = lgfpd_pkg::REF_ALL;
            end
            lgfpd_pkg::OP_REF_COL: begin
              if (col_ok) begin
                state_nxt   = lgfpd_pkg::ST_REFRESH;
                all_nxt     = 1'b0;
                col_cnt_nxt = COL_W'(in_column);
                addr_nxt    = col_base;
                ref_nxt     = lgfpd_pkg::REF_COL;
              end
            end
            lgfpd_pkg::OP_REF_ALL: begin
              state_nxt   = lgfpd_pkg::ST_REFRESH;
              all_nxt     = 1'b1;
              col_cnt_nxt = '0;
              addr_nxt    = '0;
              ref_nxt     = lgfpd_pkg::REF_ALL;
            end
            default: begin
              // unused opcode: drop
            end
          endcase
        end
      end

      lgfpd_pkg::ST_FILL: begin
        addr_nxt = addr_r + AW'(1);
        if (last_drv) begin
          drv_cnt_nxt = '0;
          col_cnt_nxt = col_cnt_r + COL_W'(1);
        end else begin
          drv_cnt_nxt = drv_cnt_r + DRV_W'(1);
        end
        if (sweep_end) begin
          // rewind to the first word of the refresh
          state_nxt   = lgfpd_pkg::ST_REFRESH;
          drv_cnt_nxt = '0;
          col_cnt_nxt = all_r ? '0 : tgt_col_r;
          addr_nxt    = all_r ? '0 : tgt_base_r;
        end
      end

      lgfpd_pkg::ST_ROW: begin
        // read one word per column; the merged word goes back next cycle.
        // Wait until the read stage holds no packet of an earlier command.
        if (!rd_valid_r) begin
          mem_rd_en    = 1'b1;
          rmw_wr_nxt   = 1'b1;
          rmw_addr_nxt = addr_r;
          addr_nxt     = addr_r + AW'(DRV);
          col_cnt_nxt  = col_cnt_r + COL_W'(1);
          if (last_col) begin
            state_nxt = lgfpd_pkg::ST_WB;
          end
        end
      end

      lgfpd_pkg::ST_WB: begin
        // last write-back lands this cycle; refresh reads start after it
        drv_cnt_nxt = '0;
        col_cnt_nxt = all_r ? '0 : tgt_col_r;
        addr_nxt    = all_r ? '0 : tgt_base_r;
        state_nxt   = (ref_r == lgfpd_pkg::REF_NONE) ? lgfpd_pkg::ST_IDLE :
                      lgfpd_pkg::ST_REFRESH;
      end

      lgfpd_pkg::ST_REFRESH: begin
        if (rd_room) begin
          mem_rd_en     = 1'b1;
          rd_valid_nxt  = 1'b1;
          rd_stripe_nxt = lgfpd_pkg::STRIPE_W'(col_cnt_r);
          rd_slot_nxt   = lgfpd_pkg::SLOT_W'(drv_cnt_r);
          rd_last_nxt   = sweep_end;
          addr_nxt      = addr_r + AW'(1);
          if (last_drv) begin
            drv_cnt_nxt = '0;
            col_cnt_nxt = col_cnt_r + COL_W'(1);
          end else begin
            drv_cnt_nxt = drv_cnt_r + DRV_W'(1);
          end
          if (sweep_end) begin
            state_nxt = lgfpd_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = lgfpd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lgfpd_pkg::ST_CLEAR;
      ref_r       <= lgfpd_pkg::REF_NONE;
      all_r       <= 1'b1;
      col_cnt_r   <= '0;
      drv_cnt_r   <= '0;
      addr_r      <= '0;
      rmw_wr_r    <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      all_r       <= all_nxt;
      col_cnt_r   <= col_cnt_nxt;
      drv_cnt_r   <= drv_cnt_nxt;
      addr_r      <= addr_nxt;
      rmw_wr_r    <= rmw_wr_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tgt_col_r   <= tgt_col_nxt;
    tgt_base_r  <= tgt_base_nxt;
    lvl_r       <= lvl_nxt;
    bsel_r      <= bsel_nxt;
    rmw_addr_r  <= rmw_addr_nxt;
    rd_stripe_r <= rd_stripe_nxt;
    rd_slot_r   <= rd_slot_nxt;
    rd_last_r   <= rd_last_nxt;
    if (out_load) begin
      out_stripe_r <= rd_stripe_r;
      out_slot_r   <= rd_slot_r;
      out_data_r   <= mem_rd_data;
      out_last_r   <= rd_last_r;
    end
  end

  lgfpd_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (addr_r),
    .rd_data (mem_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, lgfpd_pkg::WRITE_CMD, out_data_r, out_slot_r, out_stripe_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### verif/tb_led_grid_frame_packet_driver.sv
// Self-checking testbench for led_grid_frame_packet_driver.
// Keeps its own copy of the brightness grid, predicts each driver packet and
// compares the out_ stream against it. Depends on lgfpd_pkg and the top level.
`timescale 1ns / 100ps

module tb_led_grid_frame_packet_driver;
  import lgfpd_pkg::*;

  localparam int GRID_COLS   = NUM_COLUMNS_DEF;
  localparam int GRID_ROWS   = NUM_ROWS_DEF;
  localparam int SLOTS       = (GRID_ROWS + 2) / 3;
  localparam int SETTLE_CYC  = 16;
  localparam int HOLD_CYC    = 300;
  localparam int RUN_LIMIT   = 5_000_000;

  // One driver packet as it should appear on the out_ stream
  typedef struct packed {
    logic [STRIPE_W-1:0] stripe;
    logic [SLOT_W-1:0]   slot;
    logic [PACKET_W-1:0] word;
    logic                last;
  } led_packet_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Shadow grid and the packets still owed by the block, oldest first
  logic [7:0]  grid_px [GRID_COLS][GRID_ROWS];
  led_packet_t owed_packets [$];
  led_packet_t want;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_req;
  bit hold_seen;
  int mismatch_count;

  led_grid_frame_packet_driver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------

  // Rows past the grid read as zero bytes
  function automatic logic [7:0] grid_byte(input int c, input int r);
    if (r >= GRID_ROWS) return 8'd0;
    return grid_px[c][r];
  endfunction

  // Queue one packet per driver of column c; mark the last one if requested
  function automatic void owe_column(input int c, input bit final_col);
    led_packet_t p;
    for (int d = 0; d < SLOTS; d++) begin
      p.stripe = STRIPE_W'(c);
      p.slot   = SLOT_W'(d);
      p.word   = {WRITE_CMD, grid_byte(c, 3 * d), grid_byte(c, 3 * d + 1),
                  grid_byte(c, 3 * d + 2)};
      p.last   = final_col && (d == SLOTS - 1);
      owed_packets.push_back(p);
    end
  endfunction

  function automatic void owe_all_columns();
    for (int c = 0; c < GRID_COLS; c++) owe_column(c, c == GRID_COLS - 1);
  endfunction

  // Update the grid for one accepted command and queue the packets it causes.
  // Commands that name a column or row outside the grid are dropped whole.
  function automatic void apply_command(input op_t op, input logic [3:0] col,
                                        input logic [3:0] row, input logic [7:0] lvl);
    bit col_ok;
    bit row_ok;
    col_ok = col < GRID_COLS;
    row_ok = row < GRID_ROWS;
    case (op)
      OP_WRITE_PX: begin
        if (col_ok && row_ok) grid_px[col][row] = lvl;
      end
      OP_SET_PX: begin
        if (col_ok && row_ok) begin
          grid_px[col][row] = lvl;
          owe_column(col, 1'b1);
        end
      end
      OP_FILL_COL: begin
        if (col_ok) begin
          for (int r = 0; r < GRID_ROWS; r++) grid_px[col][r] = lvl;
          owe_column(col, 1'b1);
        end
      end
      OP_FILL_ROW: begin
        if (row_ok) begin
          for (int c = 0; c < GRID_COLS; c++) grid_px[c][row] = lvl;
          owe_all_columns();
        end
      end
      OP_FILL_ALL: begin
        for (int c = 0; c < GRID_COLS; c++)
          for (int r = 0; r < GRID_ROWS; r++) grid_px[c][r] = lvl;
        owe_all_columns();
      end
      OP_REF_COL: begin
        if (col_ok) owe_column(col, 1'b1);
      end
      OP_REF_ALL: owe_all_columns();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Command sender
  // ---------------------------------------------------------------------------

  // Offer one command, optionally after a short gap, and hold it until the
  // transfer. tvalid stays high on return so back-to-back commands need no
  // second assignment in the same step.
  task automatic send_cmd(input op_t op, input logic [3:0] col, input logic [3:0] row,
                          input logic [7:0] lvl);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, lvl, row, col, op};
    do @(posedge clk); while (!in_tready);
    apply_command(op, col, row, lvl);
  endtask

  // Drop tvalid and wait until every owed packet has arrived, then settle
  task automatic wait_all_packets();
    in_tvalid <= 1'b0;
    while (owed_packets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Mostly in-range commands; about one in ten is noise with any opcode and
  // indexes that may fall outside the grid.
  task automatic send_random_cmd();
    int   pick;
    op_t  op;
    logic [3:0] col;
    logic [3:0] row;
    pick = $urandom_range(99);
    col  = 4'($urandom_range(GRID_COLS - 1));
    row  = 4'($urandom_range(GRID_ROWS - 1));
    if      (pick < 30) op = OP_WRITE_PX;
    else if (pick < 50) op = OP_SET_PX;
    else if (pick < 60) op = OP_FILL_COL;
    else if (pick < 67) op = OP_FILL_ROW;
    else if (pick < 70) op = OP_FILL_ALL;
    else if (pick < 85) op = OP_REF_COL;
    else if (pick < 90) op = OP_REF_ALL;
    else begin
      op  = op_t'($urandom_range(7));
      col = 4'($urandom_range(15));
      row = 4'($urandom_range(15));
    end
    send_cmd(op, col, row, 8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // Drive out_tready: a hold-off stretch when one is requested, else random stalls
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each out_ transfer with the oldest owed packet, field by field
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_packets.size() == 0) begin
        report_mismatch($sformatf("unexpected packet tdata=%h tlast=%b", out_tdata,
                                  out_tlast));
      end else begin
        want = owed_packets.pop_front();
        if (out_tdata[3:0] !== want.stripe)
          report_mismatch($sformatf("stripe exp %0d got %0d", want.stripe,
                                    out_tdata[3:0]));
        if (out_tdata[5:4] !== want.slot)
          report_mismatch($sformatf("slot exp %0d got %0d (stripe %0d)", want.slot,
                                    out_tdata[5:4], want.stripe));
        if (out_tdata[37:6] !== want.word)
          report_mismatch($sformatf("packet exp %h got %h (stripe %0d slot %0d)",
                                    want.word, out_tdata[37:6], want.stripe, want.slot));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("tlast exp %b got %b (stripe %0d slot %0d)",
                                    want.last, out_tlast, want.stripe, want.slot));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The clearing pass after reset must leave every byte at zero
  task automatic test_cleared_grid();
    send_cmd(OP_REF_ALL, 4'd0, 4'd0, 8'd0);
    send_cmd(OP_REF_COL, 4'd11, 4'd0, 8'd0);
  endtask

  // Pixel writes at the grid corners and level extremes, with and without refresh
  task automatic test_pixel_writes();
    send_cmd(OP_WRITE_PX, 4'd0, 4'd0, 8'hFF);
    send_cmd(OP_WRITE_PX, 4'd11, 4'd11, 8'h80);
    send_cmd(OP_SET_PX, 4'd0, 4'd2, 8'h55);
    send_cmd(OP_SET_PX, 4'd11, 4'd9, 8'hAA);
    send_cmd(OP_SET_PX, 4'd6, 4'd4, 8'h01);
  endtask

  // Column, row and whole-grid fills; all but one carry all ones in the ignored field
  task automatic test_fills();
    send_cmd(OP_FILL_COL, 4'd11, 4'd15, 8'hFF);
    send_cmd(OP_FILL_COL, 4'd0, 4'd15, 8'h00);
    send_cmd(OP_FILL_ALL, 4'd15, 4'd15, 8'hA5);
    send_cmd(OP_FILL_ROW, 4'd15, 4'd0, 8'h7F);
    send_cmd(OP_FILL_ROW, 4'd0, 4'd11, 8'h80);
    send_cmd(OP_REF_COL, 4'd5, 4'd0, 8'h00);
  endtask

  // Out-of-range indexes and the unused opcode must change nothing
  task automatic test_dropped_cmds();
    send_cmd(OP_WRITE_PX, 4'd12, 4'd0, 8'hFF);
    send_cmd(OP_WRITE_PX, 4'd0, 4'd15, 8'hFF);
    send_cmd(OP_SET_PX, 4'd15, 4'd15, 8'h00);
    send_cmd(OP_FILL_COL, 4'd12, 4'd0, 8'h11);
    send_cmd(OP_FILL_ROW, 4'd0, 4'd12, 8'h22);
    send_cmd(OP_REF_COL, 4'd15, 4'd0, 8'h00);
    send_cmd(OP_NONE, 4'd3, 4'd3, 8'h33);
    send_cmd(OP_REF_ALL, 4'd0, 4'd0, 8'h00);
  endtask

  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_random_cmd();
    wait_all_packets();
  endtask

  // Block the receiver for a long stretch while refreshes keep coming, so the
  // output stages fill up and in_tready must drop
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = ~hold_req;
    send_cmd(OP_REF_ALL, 4'd0, 4'd0, 8'h00);
    send_cmd(OP_SET_PX, 4'd3, 4'd7, 8'hC3);
    send_cmd(OP_FILL_ROW, 4'd0, 4'd5, 8'h3C);
    send_cmd(OP_REF_COL, 4'd3, 4'd0, 8'h00);
    wait_all_packets();
  endtask

  // Pause the sender until every packet is out, then continue from idle
  task automatic test_idle_restart();
    send_cmd(OP_SET_PX, 4'd10, 4'd1, 8'h9E);
    wait_all_packets();
    send_cmd(OP_WRITE_PX, 4'd10, 4'd2, 8'h4D);
    send_cmd(OP_REF_COL, 4'd10, 4'd0, 8'h00);
    wait_all_packets();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    send_idle_pct  = 15;
    recv_idle_pct  = 57;
    for (int c = 0; c < GRID_COLS; c++)
      for (int r = 0; r < GRID_ROWS; r++) grid_px[c][r] = 8'd0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_cleared_grid();
    test_pixel_writes();
    test_fills();
    test_dropped_cmds();
    wait_all_packets();

    test_random_traffic(75, 15, 57);
    test_random_traffic(75, 57, 15);
    test_random_traffic(80, 0, 0);

    test_output_stall();
    test_idle_restart();

    if (mismatch_count == 0) begin
      $display("[led_grid_frame_packet_driver] OK");
    end else begin
      $display("[led_grid_frame_packet_driver] ERROR");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #(RUN_LIMIT);
    $display("[led_grid_frame_packet_driver] ERROR");
    $finish;
  end

endmodule
